// ===== hw/rtl/tlshp_pkg.sv =====
// package for the tls handshake length parser
// holds phase codes, field widths, byte counts and the result and input byte structs; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tlshp_pkg;

    localparam int unsigned LenW    = 24;
    localparam int unsigned PhaseW  = 4;
    localparam int unsigned DataW   = 8;
    localparam int unsigned ShortW  = 16;
    localparam int unsigned OffsetW = 9;

    // bytes before the first cert data byte, not counting the context
    localparam logic [OffsetW-1:0] CertHeadBytes = OffsetW'(7);

    localparam logic [LenW-1:0] ListLenBytes = LenW'(3);
    localparam logic [LenW-1:0] CertLenBytes = LenW'(3);
    localparam logic [LenW-1:0] ExtLenBytes  = LenW'(2);
    localparam logic [LenW-1:0] SchemeBytes  = LenW'(1);
    localparam logic [LenW-1:0] SigLenBytes  = LenW'(2);

    localparam logic KindCert   = 1'b0;
    localparam logic KindVerify = 1'b1;

    localparam logic [PhaseW-1:0] PhStart    = 4'd0;
    localparam logic [PhaseW-1:0] PhCtx      = 4'd1;
    localparam logic [PhaseW-1:0] PhListLen  = 4'd2;
    localparam logic [PhaseW-1:0] PhCertLen  = 4'd3;
    localparam logic [PhaseW-1:0] PhCertData = 4'd4;
    localparam logic [PhaseW-1:0] PhExtLen   = 4'd5;
    localparam logic [PhaseW-1:0] PhExtData  = 4'd6;
    localparam logic [PhaseW-1:0] PhListRest = 4'd7;
    localparam logic [PhaseW-1:0] PhScheme   = 4'd8;
    localparam logic [PhaseW-1:0] PhSigLen   = 4'd9;
    localparam logic [PhaseW-1:0] PhSig      = 4'd10;
    localparam logic [PhaseW-1:0] PhDone     = 4'd11;

    typedef struct packed {
        logic               status;
        logic [DataW-1:0]   ctx_size;
        logic [OffsetW-1:0] cert_offset;
        logic [LenW-1:0]    cert_size;
        logic [ShortW-1:0]  sig_scheme;
        logic [ShortW-1:0]  sig_len;
    } t_result;

    // one registered input byte
    typedef struct packed {
        logic             valid;
        logic [DataW-1:0] data;
        logic             last;
    } t_in_byte;

endpackage

`default_nettype wire

// ===== hw/rtl/tls_handshake_length_parser_top.sv =====
// top level of the tls handshake length parser
// depends on tlshp_pkg, tlshp_in_reg and tlshp_parser
`timescale 1ns / 1ps
`default_nettype none

// Walks one TLS 1.3 handshake body per message, one byte per request on the
// slave stream, with tlast on the final byte. i_cfg_wdata picks the message
// kind (0 Certificate, 1 CertificateVerify); a write also restarts the parse
// and must only happen while the block is idle. Each byte sits in the input
// register, then a single pass of compare and decrement logic updates the
// parse state. Bytes stream back to back at one per cycle, but a closing byte
// waits for room in the result register; the result shows on the master
// side in the cycle after the parser takes the closing byte.
// Exactly one result request comes out per message, on the closing byte,
// and only a closing byte waits when the result register is still full.
// Status (tuser) is 1 when the body was truncated, the list length was zero
// or a length overran its bound, and then every tdata field reads zero;
// fields of the other kind of message also read zero.

module tls_handshake_length_parser_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: message kind
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    // byte stream in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // last_byte
    // result stream out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] context length, [16:8] cert_offset, [40:17] cert data length,
    // [56:41] sig_scheme, [72:57] sig_len, [79:73] zero
    output logic [79:0]      m_axis_tdata,
    output logic             m_axis_tuser    // status
);

    tlshp_pkg::t_in_byte in_byte;
    tlshp_pkg::t_result  res;
    logic                take;

    // input register parts the upstream handshake from the parse step
    tlshp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_take  (take),
        .o_byte  (in_byte)
    );

    // parse state, verdict and result register
    tlshp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_byte      (in_byte),
        .o_take      (take),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    // pack the result fields, lowest field first
    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {7'd0, res.sig_len, res.sig_scheme, res.cert_size,
                           res.cert_offset, res.ctx_size};

endmodule

`default_nettype wire

// ===== hw/rtl/tlshp_in_reg.sv =====
// input register for the tls handshake length parser
// depends on tlshp_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlshp_in_reg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [tlshp_pkg::DataW-1:0] i_data,
    input  wire logic                       i_last,
    input  wire logic                       i_take,
    output tlshp_pkg::t_in_byte             o_byte
);

    logic                       r_valid;
    logic [tlshp_pkg::DataW-1:0] r_data;
    logic                       r_last;

    // free when empty or when the held byte moves on this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
            r_last <= i_last;
        end
    end

    assign o_byte = '{valid: r_valid, data: r_data, last: r_last};

endmodule

`default_nettype wire

// ===== hw/rtl/tlshp_parser.sv =====
// per-byte length walker and result register
// depends on tlshp_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlshp_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_wdata,
    input  wire tlshp_pkg::t_in_byte i_byte,
    output logic               o_take,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output tlshp_pkg::t_result o_res
);

    logic [tlshp_pkg::PhaseW-1:0] r_phase,     n_phase;
    logic [tlshp_pkg::LenW-1:0]   r_fr,        n_fr;
    logic [tlshp_pkg::LenW-1:0]   r_acc,       n_acc;
    logic [tlshp_pkg::LenW-1:0]   r_list,      n_list;
    logic [tlshp_pkg::DataW-1:0]  r_ctx_len,   n_ctx_len;
    logic [tlshp_pkg::LenW-1:0]   r_cert_size, n_cert_size;
    logic [tlshp_pkg::ShortW-1:0] r_scheme,    n_scheme;
    logic [tlshp_pkg::ShortW-1:0] r_sig_len,   n_sig_len;
    logic                         r_done,      n_done;
    logic                         r_err,       n_err;
    logic                         r_kind;
    logic                         r_res_valid;
    tlshp_pkg::t_result           r_res, n_res;

    logic                         out_free;
    logic                         step;
    logic [tlshp_pkg::LenW-1:0]   fr_dec;
    logic [tlshp_pkg::LenW-1:0]   acc_sh;
    logic [tlshp_pkg::LenW-1:0]   list_dec;
    logic [tlshp_pkg::PhaseW-1:0] mid_phase;

    assign out_free = !r_res_valid || i_res_ready;
    // a closing byte waits for room in the result register
    assign step     = i_byte.valid && (!i_byte.last || out_free);
    assign o_take   = step;

    assign fr_dec   = r_fr - tlshp_pkg::LenW'(1);
    assign acc_sh   = {r_acc[tlshp_pkg::LenW-tlshp_pkg::DataW-1:0], i_byte.data};
    assign list_dec = r_list - tlshp_pkg::LenW'(1);

    always_comb begin
        n_phase     = r_phase;
        n_fr        = r_fr;
        n_acc       = r_acc;
        n_list      = r_list;
        n_ctx_len   = r_ctx_len;
        n_cert_size = r_cert_size;
        n_scheme    = r_scheme;
        n_sig_len   = r_sig_len;
        n_done      = r_done;
        n_err       = r_err;
        mid_phase   = r_phase;

        if (r_phase != tlshp_pkg::PhDone) begin
            unique case (r_phase)
                tlshp_pkg::PhStart: begin
                    if (r_kind == tlshp_pkg::KindCert) begin
                        n_ctx_len = i_byte.data;
                        if (i_byte.data != '0) begin
                            n_phase = tlshp_pkg::PhCtx;
                            n_fr    = tlshp_pkg::LenW'(i_byte.data);
                        end else begin
                            n_phase = tlshp_pkg::PhListLen;
                            n_fr    = tlshp_pkg::ListLenBytes;
                            n_acc   = '0;
                        end
                    end else begin
                        n_phase = tlshp_pkg::PhScheme;
                        n_fr    = tlshp_pkg::SchemeBytes;
                        n_acc   = tlshp_pkg::LenW'(i_byte.data);
                    end
                end
                tlshp_pkg::PhCtx: begin
                    n_fr = fr_dec;
                    if (fr_dec == '0) begin
                        n_phase = tlshp_pkg::PhListLen;
                        n_fr    = tlshp_pkg::ListLenBytes;
                        n_acc   = '0;
                    end
                end
                tlshp_pkg::PhListLen: begin
                    n_acc = acc_sh;
                    n_fr  = fr_dec;
                    if (fr_dec == '0) begin
                        n_list = acc_sh;
                        if (acc_sh == '0) begin
                            n_phase = tlshp_pkg::PhDone;
                            n_done  = 1'b1;
                            n_err   = 1'b1;
                        end else begin
                            n_phase = tlshp_pkg::PhCertLen;
                            n_fr    = tlshp_pkg::CertLenBytes;
                            n_acc   = '0;
                        end
                    end
                end
                tlshp_pkg::PhCertLen, tlshp_pkg::PhCertData, tlshp_pkg::PhExtLen,
                tlshp_pkg::PhExtData, tlshp_pkg::PhListRest: begin
                    n_list = list_dec;
                    unique case (r_phase)
                        tlshp_pkg::PhCertLen: begin
                            n_acc = acc_sh;
                            n_fr  = fr_dec;
                            if (fr_dec == '0) begin
                                n_cert_size = acc_sh;
                                if (acc_sh != '0) begin
                                    mid_phase = tlshp_pkg::PhCertData;
                                    n_fr      = acc_sh;
                                end else begin
                                    mid_phase = tlshp_pkg::PhExtLen;
                                    n_fr      = tlshp_pkg::ExtLenBytes;
                                    n_acc     = '0;
                                end
                            end
                        end
                        tlshp_pkg::PhCertData: begin
                            n_fr = fr_dec;
                            if (fr_dec == '0) begin
                                mid_phase = tlshp_pkg::PhExtLen;
                                n_fr      = tlshp_pkg::ExtLenBytes;
                                n_acc     = '0;
                            end
                        end
                        tlshp_pkg::PhExtLen: begin
                            n_acc = acc_sh;
                            n_fr  = fr_dec;
                            if (fr_dec == '0) begin
                                if (acc_sh != '0) begin
                                    mid_phase = tlshp_pkg::PhExtData;
                                    n_fr      = acc_sh;
                                end else begin
                                    mid_phase = tlshp_pkg::PhListRest;
                                end
                            end
                        end
                        tlshp_pkg::PhExtData: begin
                            n_fr = fr_dec;
                            if (fr_dec == '0) begin
                                mid_phase = tlshp_pkg::PhListRest;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_phase = mid_phase;
                    // list exhausted: good only if the entry closed exactly in time
                    if (list_dec == '0) begin
                        n_phase = tlshp_pkg::PhDone;
                        n_done  = 1'b1;
                        n_err   = (mid_phase != tlshp_pkg::PhListRest);
                    end
                end
                tlshp_pkg::PhScheme: begin
                    n_acc = acc_sh;
                    n_fr  = fr_dec;
                    if (fr_dec == '0) begin
                        n_scheme = acc_sh[tlshp_pkg::ShortW-1:0];
                        n_phase  = tlshp_pkg::PhSigLen;
                        n_fr     = tlshp_pkg::SigLenBytes;
                        n_acc    = '0;
                    end
                end
                tlshp_pkg::PhSigLen: begin
                    n_acc = acc_sh;
                    n_fr  = fr_dec;
                    if (fr_dec == '0) begin
                        n_sig_len = acc_sh[tlshp_pkg::ShortW-1:0];
                        if (acc_sh[tlshp_pkg::ShortW-1:0] != '0) begin
                            n_phase = tlshp_pkg::PhSig;
                            n_fr    = tlshp_pkg::LenW'(acc_sh[tlshp_pkg::ShortW-1:0]);
                        end else begin
                            n_phase = tlshp_pkg::PhDone;
                            n_done  = 1'b1;
                            n_err   = 1'b0;
                        end
                    end
                end
                tlshp_pkg::PhSig: begin
                    n_fr = fr_dec;
                    if (fr_dec == '0) begin
                        n_phase = tlshp_pkg::PhDone;
                        n_done  = 1'b1;
                        n_err   = 1'b0;
                    end
                end
                default: begin
                    // unused phase codes
                    n_phase = tlshp_pkg::PhDone;
                    n_done  = 1'b1;
                    n_err   = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        n_res = '0;
        if (n_done && !n_err) begin
            if (r_kind == tlshp_pkg::KindCert) begin
                n_res.ctx_size    = n_ctx_len;
                n_res.cert_offset = tlshp_pkg::CertHeadBytes
                                  + tlshp_pkg::OffsetW'(n_ctx_len);
                n_res.cert_size   = n_cert_size;
            end else begin
                n_res.sig_scheme  = n_scheme;
                n_res.sig_len     = n_sig_len;
            end
        end else begin
            n_res.status = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (step && i_byte.last)) begin
            r_phase     <= tlshp_pkg::PhStart;
            r_fr        <= '0;
            r_acc       <= '0;
            r_list      <= '0;
            r_ctx_len   <= '0;
            r_cert_size <= '0;
            r_scheme    <= '0;
            r_sig_len   <= '0;
            r_done      <= 1'b0;
            r_err       <= 1'b0;
        end else if (step) begin
            r_phase     <= n_phase;
            r_fr        <= n_fr;
            r_acc       <= n_acc;
            r_list      <= n_list;
            r_ctx_len   <= n_ctx_len;
            r_cert_size <= n_cert_size;
            r_scheme    <= n_scheme;
            r_sig_len   <= n_sig_len;
            r_done      <= n_done;
            r_err       <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= tlshp_pkg::KindCert;
        end else if (i_cfg_we) begin
            r_kind <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (out_free) begin
            r_res_valid <= step && i_byte.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && i_byte.last) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire
